// ----- hdl/cfa_pkg.sv -----
`default_nettype none
package cfa_pkg;

    // store geometry
    localparam int MEM_CELLS = 64;
    localparam int IDX_W     = $clog2(MEM_CELLS);
    localparam int CNT_W     = $clog2(MEM_CELLS + 1);
    // width for size/position compares: wide enough for cell counts and 7-bit sizes
    localparam int SW        = ((CNT_W > 7) ? CNT_W : 7) + 1;

    // word field widths
    localparam int ACT_W     = 2;
    localparam int POL_W     = 2;
    localparam int TAG_W     = 7;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int GRANT_W   = 6;

    // actions
    localparam logic [ACT_W-1:0] ACT_FIT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PLACE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd2;

    // sequencer -> ring control
    typedef struct packed {
        logic             shift;
        logic             wr;
        logic [TAG_W-1:0] wtag;
    } ring_ctl_t;

    // result word
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRANT_W-1:0] grant;
        logic [TAG_W-1:0]   owner;
    } res_t;

endpackage
`default_nettype wire

// ----- hdl/cfa_cell.sv -----
`default_nettype none
module cfa_cell
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift,
    input  wire logic [cfa_pkg::TAG_W-1:0] tag_in,
    output logic      [cfa_pkg::TAG_W-1:0] tag_out
);

    logic [cfa_pkg::TAG_W-1:0] tag_reg;

    // one owner tag; moves one place towards the head on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (shift)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;

endmodule
`default_nettype wire

// ----- hdl/cfa_ctrl.sv -----
`default_nettype none
module cfa_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cfa_pkg::ACT_W-1:0]   action,
    input  wire logic [cfa_pkg::POL_W-1:0]   fit_policy,
    input  wire logic [cfa_pkg::TAG_W-1:0]   request_size,
    input  wire logic [cfa_pkg::POS_W-1:0]   place_start,
    input  wire logic [cfa_pkg::TAG_W-1:0]   head_tag,
    output cfa_pkg::ring_ctl_t               ring_ctl,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output cfa_pkg::res_t                    res
);

    localparam int N     = cfa_pkg::MEM_CELLS;
    localparam int IDX_W = cfa_pkg::IDX_W;
    localparam int CNT_W = cfa_pkg::CNT_W;
    localparam int SW    = cfa_pkg::SW;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);
    localparam logic [SW-1:0]    N_SW = SW'(N);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                  state_reg,      state_next;
    logic [IDX_W-1:0]            idx_reg,        idx_next;
    logic [cfa_pkg::ACT_W-1:0]   action_reg,     action_next;
    logic [cfa_pkg::POL_W-1:0]   policy_reg,     policy_next;
    logic [cfa_pkg::TAG_W-1:0]   size_reg,       size_next;
    logic [cfa_pkg::POS_W-1:0]   pos_reg,        pos_next;
    logic [CNT_W-1:0]            run_len_reg,    run_len_next;
    logic [IDX_W-1:0]            run_start_reg,  run_start_next;
    logic                        found_reg,      found_next;
    logic [CNT_W-1:0]            best_len_reg,   best_len_next;
    logic [IDX_W-1:0]            best_start_reg, best_start_next;
    logic                        busy_reg,       busy_next;
    logic [IDX_W-1:0]            wstart_reg,     wstart_next;
    cfa_pkg::res_t               res_reg,        res_next;

    logic [SW-1:0]    idx_sw, need_sw, pos_sw, ws_sw;
    logic             h_free, hole_end, fits, better, take, in_range;
    logic [CNT_W-1:0] cur_len;
    logic [IDX_W-1:0] cur_start, pick_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        action_reg     <= action_next;
        policy_reg     <= policy_next;
        size_reg       <= size_next;
        pos_reg        <= pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        found_reg      <= found_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        busy_reg       <= busy_next;
        wstart_reg     <= wstart_next;
        res_reg        <= res_next;
    end

    // hole tracking on the tag passing the head
    always_comb
    begin
        idx_sw    = SW'(idx_reg);
        need_sw   = SW'(size_reg);
        pos_sw    = SW'(pos_reg);
        ws_sw     = SW'(wstart_reg);
        h_free    = (head_tag == '0);
        cur_len   = h_free ? (run_len_reg + 1'b1) : run_len_reg;
        cur_start = (run_len_reg == '0) ? idx_reg : run_start_reg;
        hole_end  = h_free ? (idx_reg == LAST) : (run_len_reg != '0);
        fits      = (SW'(cur_len) >= need_sw);
        unique case (policy_reg)
            cfa_pkg::POL_FIRST: better = !found_reg;
            cfa_pkg::POL_BEST:  better = !found_reg || (cur_len < best_len_reg);
            cfa_pkg::POL_WORST: better = !found_reg || (cur_len > best_len_reg);
            default:            better = 1'b0;
        endcase
        take       = (action_reg == cfa_pkg::ACT_FIT) && hole_end && fits && better;
        pick_start = take ? cur_start : best_start_reg;
        in_range   = (idx_sw >= pos_sw) && (idx_sw < pos_sw + need_sw);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        action_next     = action_reg;
        policy_next     = policy_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        busy_next       = busy_reg;
        wstart_next     = wstart_reg;
        res_next        = res_reg;
        ring_ctl.shift  = 1'b0;
        ring_ctl.wr     = 1'b0;
        ring_ctl.wtag   = size_reg;
        res_valid       = 1'b0;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next   = action;
                    policy_next   = fit_policy;
                    size_next     = request_size;
                    pos_next      = place_start;
                    idx_next      = '0;
                    run_len_next  = '0;
                    found_next    = 1'b0;
                    best_len_next = '0;
                    busy_next     = 1'b0;
                    res_next      = '0;
                    state_next    = S_DONE;
                    if ((action == cfa_pkg::ACT_FIT) || (action == cfa_pkg::ACT_PLACE))
                    begin
                        priority if ((request_size == '0) || (SW'(request_size) > N_SW))
                        begin
                            res_next.status = cfa_pkg::ST_BADSIZE;
                        end
                        else if ((action == cfa_pkg::ACT_PLACE) &&
                                 (SW'(place_start) + SW'(request_size) > N_SW))
                        begin
                            res_next.status = cfa_pkg::ST_NOROOM;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (action == cfa_pkg::ACT_READ)
                    begin
                        if (SW'(place_start) >= N_SW)
                        begin
                            res_next.status = cfa_pkg::ST_NOROOM;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ring_ctl.shift = 1'b1;
                idx_next       = idx_reg + 1'b1;
                run_len_next   = h_free ? cur_len : '0;
                run_start_next = cur_start;
                if (take)
                begin
                    found_next      = 1'b1;
                    best_len_next   = cur_len;
                    best_start_next = cur_start;
                end
                if (in_range && !h_free)
                begin
                    busy_next = 1'b1;
                end
                if ((action_reg == cfa_pkg::ACT_READ) && (idx_sw == pos_sw))
                begin
                    res_next.owner = head_tag;
                end
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_DONE;
                    if (action_reg == cfa_pkg::ACT_FIT)
                    begin
                        if (found_reg || take)
                        begin
                            wstart_next   = pick_start;
                            res_next.grant = cfa_pkg::GRANT_W'(SW'(pick_start));
                            state_next    = S_WRITE;
                        end
                        else
                        begin
                            res_next.status = cfa_pkg::ST_NOROOM;
                        end
                    end
                    else if (action_reg == cfa_pkg::ACT_PLACE)
                    begin
                        if (!(busy_reg || (in_range && !h_free)))
                        begin
                            wstart_next    = IDX_W'(pos_sw);
                            res_next.grant = pos_reg;
                            state_next     = S_WRITE;
                        end
                        else
                        begin
                            res_next.status = cfa_pkg::ST_NOROOM;
                        end
                    end
                end
            end

            S_WRITE:
            begin
                ring_ctl.shift = 1'b1;
                ring_ctl.wr    = (idx_sw >= ws_sw) && (idx_sw < ws_sw + need_sw);
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ----- hdl/contiguous_fit_allocator.sv -----
`default_nettype none
// Channel  Handshake            Word
// -------  -------------------  -------------------------------------------------
// in       in_valid/in_ready    action, fit_policy, request_size, place_start
// out      out_valid/out_ready  status, grant_start, cell_owner
//
// A word is accepted, scanned as the tag ring turns once past the head, written
// in a second turn of the ring when cells are claimed, and then handed over. A
// read or a request refused after the scan skips the write pass; a rejected
// size, a place range running off the top of the store or an unknown action
// goes straight from acceptance to hand-over.
// The single-ported head of the ring sets these passes.
// Reset clears every cell tag to free at once; no clearing pass is needed.
// A finished word sits in the output register; the next input word is accepted
// while it waits for out_ready.
module contiguous_fit_allocator
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cfa_pkg::ACT_W-1:0]     action,
    input  wire logic [cfa_pkg::POL_W-1:0]     fit_policy,
    input  wire logic [cfa_pkg::TAG_W-1:0]     request_size,
    input  wire logic [cfa_pkg::POS_W-1:0]     place_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [cfa_pkg::STAT_W-1:0]    status,
    output logic      [cfa_pkg::GRANT_W-1:0]   grant_start,
    output logic      [cfa_pkg::TAG_W-1:0]     cell_owner
);

    localparam int N = cfa_pkg::MEM_CELLS;

    cfa_pkg::ring_ctl_t        ring_ctl;
    cfa_pkg::res_t             res;
    logic                      res_valid;
    logic                      res_take;
    logic [cfa_pkg::TAG_W-1:0] ring_tag [N];

    logic          out_valid_reg, out_valid_next;
    cfa_pkg::res_t out_res_reg,   out_res_next;

    // Ring of tag cells. Cell 0 is the head the sequencer watches; on every
    // shift each cell takes its upper neighbour's tag and the last cell takes
    // the head's tag back, or the new owner tag during a claim. After one
    // full turn of the ring every tag is home again.
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [cfa_pkg::TAG_W-1:0] tag_in;
            if (g == N - 1)
            begin : g_tail
                assign tag_in = ring_ctl.wr ? ring_ctl.wtag : ring_tag[0];
            end
            else
            begin : g_mid
                assign tag_in = ring_tag[g + 1];
            end
            cfa_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (ring_ctl.shift),
                .tag_in  (tag_in),
                .tag_out (ring_tag[g])
            );
        end
    endgenerate

    // Scan and claim sequencer
    cfa_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .fit_policy   (fit_policy),
        .request_size (request_size),
        .place_start  (place_start),
        .head_tag     (ring_tag[0]),
        .ring_ctl     (ring_ctl),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    // Output register: takes the finished word when empty or being emptied
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign grant_start = out_res_reg.grant;
    assign cell_owner  = out_res_reg.owner;

endmodule
`default_nettype wire
